[sv/vector_terminal_coordinate_encoder_defines.svh]
// Assertion macros shared by the checker of the coordinate encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef VECTOR_TERMINAL_COORDINATE_ENCODER_DEFINES_SVH
`define VECTOR_TERMINAL_COORDINATE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("coordinate encoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("coordinate encoder check failed");

// Next-cycle implication that is also checked across reset.
`define VTCE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("coordinate encoder check failed");

`endif

[sv/vtce_pkg.sv]
// Shared types and constants of the graph-mode coordinate encoder.
// Depends on nothing; imported by every module of the block.
package vtce_pkg;

    // Screen size; both values must stay in 2..1024.
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 780;

    // Coordinate split: a 10-bit address in a high and a low 5-bit half.
    localparam int COORD_W = 10;
    localparam int LOW_W   = 5;
    localparam int IN_W    = 16;
    localparam int BYTE_W  = 7;
    localparam int TDATA_IN_W  = 2 * IN_W;
    localparam int TDATA_OUT_W = 8;

    // Terminal byte codes and address byte offsets.
    localparam logic [BYTE_W-1:0] BYTE_GRAPH = 7'd29;
    localparam logic [BYTE_W-1:0] BYTE_ALPHA = 7'd31;
    localparam logic [BYTE_W-1:0] HI_BASE    = 7'd32;
    localparam logic [BYTE_W-1:0] LO_Y_BASE  = 7'd96;
    localparam logic [BYTE_W-1:0] LO_X_BASE  = 7'd64;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    // Byte slots of one job, in the order they go out.
    localparam int SLOT_N     = 5;
    localparam int SLOT_IDX_W = $clog2(SLOT_N);
    localparam int SLOT_CTRL  = 0;
    localparam int SLOT_HY    = 1;
    localparam int SLOT_LY    = 2;
    localparam int SLOT_HX    = 3;
    localparam int SLOT_LX    = 4;

    // One classified command: which slots to send and their bytes.
    typedef struct packed {
        logic [SLOT_N-1:0]             mask;
        logic [SLOT_N-1:0][BYTE_W-1:0] data;
    } job_t;

    // Job queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

[sv/vtce_queue.sv]
// Small job queue that decouples the command front end from the byte back end.
// Depends on vtce_pkg for the job type and the queue depth.
module vtce_queue
    import vtce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Occupancy follows the push and pop strobes.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/vtce_front.sv]
// Front end: accepts commands, clamps the point and picks the bytes to send.
// Depends on vtce_pkg; keeps the last point sent and feeds the job queue.
module vtce_front
    import vtce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,  // x_coord[15:0], y_coord[31:16]
    input  logic [1:0]            s_axis_tuser,  // cmd[1:0]
    input  logic                  q_full,
    output logic                  q_push,
    output job_t                  q_job
);

    localparam logic signed [IN_W-1:0] X_MAX = IN_W'(SCREEN_WIDTH - 1);
    localparam logic signed [IN_W-1:0] Y_MAX = IN_W'(SCREEN_HEIGHT - 1);

    logic [COORD_W-1:0] last_x_reg;
    logic [COORD_W-1:0] last_y_reg;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               accept;
    logic               keep_point;
    logic               hy_chg;
    logic               ly_chg;
    logic               hx_chg;
    cmd_t               cmd;

    // Clamp a signed request to 0..limit.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [IN_W-1:0] v,
        input logic signed [IN_W-1:0] limit
    );
        logic [COORD_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > limit)
        begin
            r = limit[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign cmd           = cmd_t'(s_axis_tuser);

    assign x = clamp_coord($signed(s_axis_tdata[IN_W-1:0]), X_MAX);
    assign y = clamp_coord($signed(s_axis_tdata[TDATA_IN_W-1:IN_W]), Y_MAX);

    // Address halves that differ from the last point.
    assign hy_chg = (y[COORD_W-1:LOW_W] != last_y_reg[COORD_W-1:LOW_W]);
    assign ly_chg = (y[LOW_W-1:0] != last_y_reg[LOW_W-1:0]);
    assign hx_chg = (x[COORD_W-1:LOW_W] != last_x_reg[COORD_W-1:LOW_W]);

    // Build the job: all address bytes are formed, the mask picks them.
    always_comb
    begin
        q_job.mask            = '0;
        q_job.data[SLOT_CTRL] = BYTE_GRAPH;
        q_job.data[SLOT_HY]   = HI_BASE + BYTE_W'(y[COORD_W-1:LOW_W]);
        q_job.data[SLOT_LY]   = LO_Y_BASE + BYTE_W'(y[LOW_W-1:0]);
        q_job.data[SLOT_HX]   = HI_BASE + BYTE_W'(x[COORD_W-1:LOW_W]);
        q_job.data[SLOT_LX]   = LO_X_BASE + BYTE_W'(x[LOW_W-1:0]);
        keep_point            = 1'b0;
        unique case (cmd)
            CMD_START:
            begin
                q_job.mask = '1;
                keep_point = 1'b1;
            end
            CMD_DRAW:
            begin
                q_job.mask[SLOT_HY] = hy_chg;
                q_job.mask[SLOT_LY] = hx_chg || ly_chg;
                q_job.mask[SLOT_HX] = hx_chg;
                q_job.mask[SLOT_LX] = 1'b1;
                keep_point          = 1'b1;
            end
            CMD_END:
            begin
                q_job.data[SLOT_CTRL] = BYTE_ALPHA;
                q_job.mask[SLOT_CTRL] = 1'b1;
            end
            default:
            begin
                // The unused code is taken and dropped.
                q_job.mask = '0;
            end
        endcase
    end

    assign q_push = accept && (q_job.mask != '0);

    // Last point, updated by start and draw.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else if (accept && keep_point)
        begin
            last_x_reg <= x;
            last_y_reg <= y;
        end
    end

endmodule

[sv/vtce_back.sv]
// Back end: takes jobs from the queue and sends their bytes one beat at a time.
// Depends on vtce_pkg; drives the output register of the stream.
module vtce_back
    import vtce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_not_empty,
    input  job_t                   q_job,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // out_byte[6:0], zero[7]
    output logic                   m_axis_tlast   // last_byte
);

    logic [SLOT_N-1:0]             mask_reg;
    logic [SLOT_N-1:0]             mask_next;
    logic [SLOT_N-1:0][BYTE_W-1:0] data_reg;
    logic [SLOT_N-1:0]             mask_rest;
    logic [SLOT_IDX_W-1:0]         sel;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [BYTE_W-1:0]             out_byte_reg;
    logic                          out_last_reg;
    logic                          advance;
    logic                          emit;
    logic                          free;

    // Lowest pending slot goes out first.
    always_comb
    begin
        sel = '0;
        for (int i = SLOT_N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SLOT_IDX_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);
    assign advance   = !out_valid_reg || m_axis_tready;
    assign emit      = advance && (mask_reg != '0);
    assign free      = (mask_reg == '0) || (emit && (mask_rest == '0));
    assign q_pop     = free && q_not_empty;

    // Pending slots and output valid.
    always_comb
    begin
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            mask_next = q_job.mask;
        end
        else if (emit)
        begin
            mask_next = mask_rest;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_job.data;
        end
        if (emit)
        begin
            out_byte_reg <= data_reg[sel];
            out_last_reg <= (mask_rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[sv/vector_terminal_coordinate_encoder.sv]
// Top level of the graph-mode coordinate encoder.
// Depends on vtce_pkg, vtce_front, vtce_queue and vtce_back.

// Turns start, draw and end commands into the byte stream of a vector display
// terminal. A start clamps the point to the screen and sends the graph-mode
// byte and all four address bytes; a draw sends the address bytes that changed
// since the last point, low y also when high x changed, low x always; an end
// sends the alpha-mode byte. The unused command code is accepted and sends
// nothing. The last byte of each command is marked with tlast. The output moves
// one byte per cycle while the receiver is ready, from a single output register,
// so a start sends five bytes, a draw one to four and an end one; that register
// sets the sustained rate. Commands are accepted every cycle while the two-entry
// job queue has room, so input and output stall independently. Each job passes
// the job queue and the slot registers before its bytes reach the output register.
module vector_terminal_coordinate_encoder
    import vtce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // x_coord[15:0], y_coord[31:16]
    input  logic [1:0]             s_axis_tuser,  // cmd[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // out_byte[6:0], zero[7]
    output logic                   m_axis_tlast   // last_byte
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    job_t push_job;
    job_t pop_job;

    // Command classification and point tracking.
    vtce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    // Job queue between the two sides.
    vtce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    // Byte serializer and output register.
    vtce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sv/vtce_checker.sv]
// Port-level checks of the coordinate encoder, bound to the top level.
// Depends on vtce_pkg and the assertion macros of the defines header.
`include "vector_terminal_coordinate_encoder_defines.svh"

module vtce_checker
    import vtce_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic                 out_stall;
    logic [TDATA_OUT_W:0] out_payload;
    logic                 out_last_ok;
    logic                 out_graph;

    // Output beat views used by the checks below.
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_payload = {m_axis_tlast, m_axis_tdata};
    assign out_last_ok = (m_axis_tdata[6:5] == 2'b10) || (m_axis_tdata == {1'b0, BYTE_ALPHA});
    assign out_graph   = m_axis_tvalid && (m_axis_tdata == {1'b0, BYTE_GRAPH});

    // A stalled output beat keeps its byte and its last mark.
    `VTCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_payload))

    // Nothing is offered in the cycle after reset.
    `VTCE_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !m_axis_tvalid)

    // A command always closes on a low-x byte or on the alpha-mode byte.
    `VTCE_ASSERT_NOW(a_last_kind, clk, rst_n, m_axis_tvalid && m_axis_tlast, out_last_ok)

    // The graph-mode byte opens a start and is never its last beat.
    `VTCE_ASSERT_NOW(a_graph_open, clk, rst_n, out_graph, !m_axis_tlast)

endmodule

bind vector_terminal_coordinate_encoder vtce_checker u_vtce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[test/vector_terminal_coordinate_encoder_tb.sv]
// Self-checking testbench for the graph-mode coordinate encoder.
// Depends on vtce_pkg and vector_terminal_coordinate_encoder; reads no files.
module vector_terminal_coordinate_encoder_tb;
    import vtce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth command code is not in the package enum; it must emit nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One terminal byte as it should leave the block.
    typedef struct {
        logic [BYTE_W-1:0] code;
        logic              last;
    } term_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;  // x_coord[15:0], y_coord[31:16]
    logic [1:0]             s_axis_tuser = '0;  // cmd[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;       // out_byte[6:0], zero[7]
    logic                   m_axis_tlast;       // last_byte

    // Predictor state: the last point that went out, and the bytes still owed.
    logic [COORD_W-1:0] pen_x = '0;
    logic [COORD_W-1:0] pen_y = '0;
    term_byte_t         pending_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;

    vector_terminal_coordinate_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clamp a signed 16-bit request onto the screen.
    function automatic logic [COORD_W-1:0] clamp_to_screen(input logic signed [IN_W-1:0] raw,
                                                          input int limit);
        int v;
        v = raw;
        if (v < 0)
            v = 0;
        if (v >= limit)
            v = limit - 1;
        return v[COORD_W-1:0];
    endfunction

    // Work out the bytes one accepted command must produce and move the pen.
    task automatic encode_expected(input logic [1:0] cmd, input logic [IN_W-1:0] x_raw,
                                   input logic [IN_W-1:0] y_raw);
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [BYTE_W-1:0]  burst[$];
        bit                 hy_moved;
        bit                 hx_moved;
        bit                 ly_moved;
        if (cmd == CMD_END)
            burst.push_back(BYTE_ALPHA);
        else if (cmd == CMD_START || cmd == CMD_DRAW)
        begin
            px = clamp_to_screen(x_raw, SCREEN_WIDTH);
            py = clamp_to_screen(y_raw, SCREEN_HEIGHT);
            if (cmd == CMD_START)
            begin
                burst.push_back(BYTE_GRAPH);
                burst.push_back(HI_BASE + py[COORD_W-1:LOW_W]);
                burst.push_back(LO_Y_BASE + py[LOW_W-1:0]);
                burst.push_back(HI_BASE + px[COORD_W-1:LOW_W]);
            end
            else
            begin
                // A draw repeats the address bytes that changed, low y also when high x moved.
                hy_moved = py[COORD_W-1:LOW_W] != pen_y[COORD_W-1:LOW_W];
                hx_moved = px[COORD_W-1:LOW_W] != pen_x[COORD_W-1:LOW_W];
                ly_moved = py[LOW_W-1:0] != pen_y[LOW_W-1:0];
                if (hy_moved)
                    burst.push_back(HI_BASE + py[COORD_W-1:LOW_W]);
                if (hx_moved || ly_moved)
                    burst.push_back(LO_Y_BASE + py[LOW_W-1:0]);
                if (hx_moved)
                    burst.push_back(HI_BASE + px[COORD_W-1:LOW_W]);
            end
            burst.push_back(LO_X_BASE + px[LOW_W-1:0]);
            pen_x = px;
            pen_y = py;
        end
        foreach (burst[i])
            pending_bytes.push_back('{code: burst[i], last: (i == burst.size() - 1)});
    endtask

    // Offer one command beat, with random idle cycles ahead of it.
    task automatic send_command(input logic [1:0] cmd, input logic [IN_W-1:0] x_raw,
                                input logic [IN_W-1:0] y_raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {y_raw, x_raw};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encode_expected(cmd, x_raw, y_raw);
    endtask

    // Pick a coordinate: mostly near the pen if asked, sometimes anywhere, at an edge or raw.
    function automatic logic [IN_W-1:0] pick_coord(input int limit, input logic [COORD_W-1:0] pen,
                                                   input bit near);
        int roll;
        int v;
        roll = $urandom_range(99);
        if (near && roll < 12)
            v = pen;
        else if (near && roll < 60)
            v = int'(pen) + int'($urandom_range(80)) - 40;
        else if (roll < 75)
            v = $urandom_range(limit - 1);
        else if (roll < 88)
        begin
            case ($urandom_range(5))
                0: v = 0;
                1: v = limit - 1;
                2: v = limit;
                3: v = -1;
                4: v = 32767;
                default: v = -32768;
            endcase
        end
        else
            v = $urandom_range(65535);
        return v[IN_W-1:0];
    endfunction

    // A draw straight after reset encodes against the origin.
    task automatic test_draw_from_reset();
        send_command(CMD_DRAW, 16'd37, 16'd5);
        send_command(CMD_DRAW, 16'd37, 16'd5);
    endtask

    // Start clamps every kind of out-of-range point onto the screen.
    task automatic test_start_extremes();
        send_command(CMD_START, 16'd0, 16'd0);
        send_command(CMD_START, 16'h7FFF, 16'h7FFF);
        send_command(CMD_START, 16'h8000, 16'h8000);
        send_command(CMD_START, 16'd1023, 16'd779);
        send_command(CMD_START, 16'd1024, 16'd780);
        send_command(CMD_START, 16'hFFFF, 16'hFFFF);
    endtask

    // Draws that move each half of each coordinate alone and together.
    task automatic test_draw_byte_selection();
        send_command(CMD_START, 16'd100, 16'd100);
        send_command(CMD_DRAW, 16'd101, 16'd100);
        send_command(CMD_DRAW, 16'd101, 16'd101);
        send_command(CMD_DRAW, 16'd101, 16'd140);
        send_command(CMD_DRAW, 16'd101, 16'd172);
        send_command(CMD_DRAW, 16'd140, 16'd172);
        send_command(CMD_DRAW, 16'd500, 16'd20);
    endtask

    // End ignores its point and keeps the pen; the unused code emits nothing.
    task automatic test_end_and_unused();
        send_command(CMD_END, 16'h8000, 16'h7FFF);
        send_command(CMD_UNUSED, 16'd1, 16'd1);
        send_command(CMD_DRAW, 16'd500, 16'd20);
        send_command(CMD_END, 16'hFFFF, 16'h0000);
    endtask

    // Random drawing sessions, mixed with stray commands and raw noise.
    task automatic test_random_sessions(input int item_goal);
        int sent;
        int draws;
        logic [1:0] cmd;
        sent = 0;
        while (sent < item_goal)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_command(CMD_START, pick_coord(SCREEN_WIDTH, pen_x, 1'b0),
                             pick_coord(SCREEN_HEIGHT, pen_y, 1'b0));
                draws = $urandom_range(1, 8);
                repeat (draws)
                    send_command(CMD_DRAW, pick_coord(SCREEN_WIDTH, pen_x, 1'b1),
                                 pick_coord(SCREEN_HEIGHT, pen_y, 1'b1));
                send_command(CMD_END, 16'($urandom), 16'($urandom));
                sent += draws + 2;
            end
            else
            begin
                cmd = 2'($urandom_range(3));
                send_command(cmd, 16'($urandom), 16'($urandom));
                if (cmd != CMD_UNUSED)
                    sent++;
            end
        end
    endtask

    // Receiver: random back-pressure, decided at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready = 1'b0;
        else
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every output beat with the oldest byte still owed.
    always @(posedge clk)
    begin : check_output_beat
        term_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== {1'b0, want.code})
                begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, {1'b0, want.code}, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last_byte mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed tests, then random traffic in three idling phases.
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 83;
        test_draw_from_reset();
        test_start_extremes();
        test_draw_byte_selection();
        test_end_and_unused();
        test_random_sessions(160);

        send_idle_pct = 83;
        recv_idle_pct = 34;
        test_random_sessions(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(160);

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("vector_terminal_coordinate_encoder_tb OK");
        else
            $display("vector_terminal_coordinate_encoder_tb NOT OK");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("vector_terminal_coordinate_encoder_tb NOT OK");
        $finish;
    end

endmodule
